FILE: rtl/core/ffba_pkg.sv
package ffba_pkg;

	localparam int MaxBlocks = 64;
	localparam int IdxW = $clog2(MaxBlocks);
	localparam int CntW = $clog2(MaxBlocks + 1);

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE = 2'd1;
	localparam logic [1:0] KIND_RESIZE = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ZERO = 3'd1;
	localparam logic [2:0] ST_OOM = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_BAD = 3'd4;

	localparam logic CFG_HEADER = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] request_size;
		logic [31:0] block_address;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic [2:0] status;
		logic [6:0] block_count;
		logic [31:0] heap_used;
	} out_item_t;

endpackage

FILE: rtl/core/first_fit_block_allocator.sv
// First-fit heap block allocator. Blocks are kept in address order in an internal
// table of 64 entries (start, size, free mark). One item is taken at a time: the
// sequencer reads the table one entry per cycle through a single registered read
// port. The worst case is a resize that must move, which scans once to find the old
// block and once more for a fit. The result is held in an output register until
// taken, and the next input beat can be accepted in the cycle after that.
module first_fit_block_allocator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ffba_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ffba_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [31:0] cfg_wdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIND = 3'd1; // look for matching address
	localparam logic [2:0] S_FIT = 3'd2; // look for first free fit
	localparam logic [2:0] S_APPEND = 3'd3;
	localparam logic [2:0] S_REL = 3'd4; // release found entry
	localparam logic [2:0] S_DONE = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [31:0] mem_start [ffba_pkg::MaxBlocks];
	logic [31:0] mem_size [ffba_pkg::MaxBlocks];
	logic mem_free [ffba_pkg::MaxBlocks];

	logic [2:0] state_q;
	logic [ffba_pkg::CntW-1:0] count_q;
	logic [31:0] brk_q;
	logic [6:0] hdr_q;
	logic [31:0] limit_q;
	ffba_pkg::in_item_t item_q;
	logic [ffba_pkg::CntW-1:0] ptr_q;
	logic rd_valid_q;
	logic [ffba_pkg::IdxW-1:0] rd_idx_q;
	logic [31:0] rd_start_q, rd_size_q;
	logic rd_free_q;
	logic [ffba_pkg::IdxW-1:0] old_idx_q;
	logic [31:0] old_start_q;
	logic resize_move_q;
	logic [31:0] res_addr_q;
	logic [2:0] res_st_q;
	ffba_pkg::out_item_t out_q;

	logic [32:0] hdr_len;
	logic [33:0] end_sum;
	logic [32:0] user_off;
	logic find_hit, fit_hit;
	logic rd_en;
	logic [ffba_pkg::IdxW-1:0] rd_addr;
	logic we;
	logic [ffba_pkg::IdxW-1:0] w_idx;
	logic [31:0] w_start, w_size;
	logic w_free, w_all;

	assign hdr_len = (hdr_q == 7'd0) ? 33'd1 : {26'd0, hdr_q};
	assign end_sum = {2'b0, brk_q} + {1'b0, hdr_len} + {2'b0, item_q.request_size};
	assign user_off = {1'b0, rd_start_q} + hdr_len;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = out_q;

	assign find_hit = (state_q == S_FIND) && rd_valid_q
		&& (user_off == {1'b0, item_q.block_address});
	assign fit_hit = (state_q == S_FIT) && rd_valid_q && rd_free_q
		&& (rd_size_q >= item_q.request_size);

	// Scan pointer issues one read per cycle; the data returns registered in the next cycle.
	// No read is issued on a hit, so the next scan never sees a stale entry.
	assign rd_en = (state_q == S_FIND || state_q == S_FIT) && (ptr_q < count_q)
		&& !find_hit && !fit_hit;
	assign rd_addr = ptr_q[ffba_pkg::IdxW-1:0];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_start_q <= mem_start[rd_addr];
			rd_size_q <= mem_size[rd_addr];
			rd_free_q <= mem_free[rd_addr];
		end
		if (we) begin
			mem_free[w_idx] <= w_free;
			if (w_all) begin
				mem_start[w_idx] <= w_start;
				mem_size[w_idx] <= w_size;
			end
		end
	end

	always_comb begin
		we = 1'b0;
		w_idx = rd_idx_q;
		w_start = brk_q;
		w_size = item_q.request_size;
		w_free = 1'b0;
		w_all = 1'b0;
		if (fit_hit)
			we = 1'b1;
		else if (state_q == S_APPEND && !(count_q >= ffba_pkg::CntW'(ffba_pkg::MaxBlocks))
				&& end_sum <= {2'b0, limit_q}) begin
			we = 1'b1;
			w_idx = count_q[ffba_pkg::IdxW-1:0];
			w_all = 1'b1;
		end else if (state_q == S_REL
				&& !({1'b0, old_idx_q} + 1'b1 == {1'b0, count_q})) begin
			we = 1'b1;
			w_idx = old_idx_q;
			w_free = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			brk_q <= '0;
			hdr_q <= 7'd32;
			limit_q <= 32'd65536;
			ptr_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ffba_pkg::CFG_HEADER)
					hdr_q <= cfg_wdata[6:0];
				else
					limit_q <= cfg_wdata;
			end
			rd_valid_q <= rd_en;
			rd_idx_q <= rd_addr;
			if (rd_en)
				ptr_q <= ptr_q + 1'b1;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						ptr_q <= '0;
						res_addr_q <= '0;
						res_st_q <= ffba_pkg::ST_OK;
						resize_move_q <= 1'b0;
						case (in_data.kind)
							ffba_pkg::KIND_ALLOC: begin
								if (in_data.request_size == '0) begin
									res_st_q <= ffba_pkg::ST_ZERO;
									state_q <= S_DONE;
								end else
									state_q <= S_FIT;
							end
							ffba_pkg::KIND_FREE: begin
								state_q <= (in_data.block_address == '0) ? S_DONE : S_FIND;
							end
							ffba_pkg::KIND_RESIZE: begin
								if (in_data.block_address == '0) begin
									if (in_data.request_size == '0) begin
										res_st_q <= ffba_pkg::ST_ZERO;
										state_q <= S_DONE;
									end else
										state_q <= S_FIT;
								end else
									state_q <= S_FIND;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FIND: begin
					if (find_hit) begin
						old_idx_q <= rd_idx_q;
						old_start_q <= rd_start_q;
						ptr_q <= '0;
						if (item_q.kind == ffba_pkg::KIND_FREE || item_q.request_size == '0)
							state_q <= S_REL;
						else if (rd_size_q >= item_q.request_size) begin
							res_addr_q <= item_q.block_address;
							state_q <= S_DONE;
						end else begin
							resize_move_q <= 1'b1;
							state_q <= S_FIT;
						end
					end else if (!rd_en && !rd_valid_q) begin
						res_st_q <= ffba_pkg::ST_BAD;
						state_q <= S_DONE;
					end
				end
				S_FIT: begin
					if (fit_hit) begin
						res_addr_q <= user_off[31:0];
						state_q <= resize_move_q ? S_REL : S_DONE;
					end else if (!rd_en && !rd_valid_q)
						state_q <= S_APPEND;
				end
				S_APPEND: begin
					if (count_q >= ffba_pkg::CntW'(ffba_pkg::MaxBlocks)) begin
						res_st_q <= ffba_pkg::ST_FULL;
						state_q <= S_DONE;
					end else if (end_sum > {2'b0, limit_q}) begin
						res_st_q <= ffba_pkg::ST_OOM;
						state_q <= S_DONE;
					end else begin
						res_addr_q <= brk_q + hdr_len[31:0];
						brk_q <= end_sum[31:0];
						count_q <= count_q + 1'b1;
						state_q <= resize_move_q ? S_REL : S_DONE;
					end
				end
				S_REL: begin
					if ({1'b0, old_idx_q} + 1'b1 == {1'b0, count_q}) begin
						brk_q <= old_start_q;
						count_q <= count_q - 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_q.result_address <= res_addr_q;
					out_q.status <= res_st_q;
					out_q.block_count <= 7'(count_q);
					out_q.heap_used <= brk_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ffba_pkg::CntW'(ffba_pkg::MaxBlocks))
		else $error("block count above table depth");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_ok_nonnull: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ffba_pkg::ST_OK |-> out_data.result_address == '0)
		else $error("failed item returned an address");

endmodule

FILE: tb/ffba_checker.sv
`timescale 1ns / 100ps

module ffba_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input ffba_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input ffba_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [31:0] cfg_wdata,
	output int fail_count,
	output int pending
);

	logic [31:0] blk_start [ffba_pkg::MaxBlocks];
	logic [31:0] blk_size [ffba_pkg::MaxBlocks];
	logic blk_free [ffba_pkg::MaxBlocks];
	int blk_count;
	logic [31:0] brk;
	logic [6:0] hdr_cfg;
	logic [31:0] limit_cfg;
	ffba_pkg::out_item_t expected_q [$];

	function automatic logic [32:0] hdr_len();
		return (hdr_cfg == 0) ? 33'd1 : {26'd0, hdr_cfg};
	endfunction

	function automatic logic [2:0] heap_alloc(input logic [31:0] size,
			output logic [31:0] addr);
		logic [33:0] end_off;
		addr = '0;
		if (size == 0)
			return ffba_pkg::ST_ZERO;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] && blk_size[i] >= size) begin
				blk_free[i] = 1'b0;
				addr = 32'({1'b0, blk_start[i]} + hdr_len());
				return ffba_pkg::ST_OK;
			end
		end
		if (blk_count >= ffba_pkg::MaxBlocks)
			return ffba_pkg::ST_FULL;
		end_off = {2'b0, brk} + {1'b0, hdr_len()} + {2'b0, size};
		if (end_off > {2'b0, limit_cfg})
			return ffba_pkg::ST_OOM;
		blk_start[blk_count] = brk;
		blk_size[blk_count] = size;
		blk_free[blk_count] = 1'b0;
		blk_count++;
		addr = 32'({1'b0, brk} + hdr_len());
		brk = end_off[31:0];
		return ffba_pkg::ST_OK;
	endfunction

	function automatic int lookup_block(input logic [31:0] addr);
		for (int i = 0; i < blk_count; i++)
			if ({1'b0, blk_start[i]} + hdr_len() == {1'b0, addr})
				return i;
		return -1;
	endfunction

	function automatic void release_block(input int idx);
		if (idx + 1 == blk_count) begin
			brk = blk_start[idx];
			blk_count--;
		end else begin
			blk_free[idx] = 1'b1;
		end
	endfunction

	function automatic logic [2:0] heap_free(input logic [31:0] addr);
		int idx;
		if (addr == 0)
			return ffba_pkg::ST_OK;
		idx = lookup_block(addr);
		if (idx < 0)
			return ffba_pkg::ST_BAD;
		release_block(idx);
		return ffba_pkg::ST_OK;
	endfunction

	function automatic ffba_pkg::out_item_t apply_request(input ffba_pkg::in_item_t req);
		ffba_pkg::out_item_t res;
		logic [31:0] addr;
		logic [2:0] st;
		int idx;
		addr = '0;
		st = ffba_pkg::ST_OK;
		case (req.kind)
			ffba_pkg::KIND_ALLOC: st = heap_alloc(req.request_size, addr);
			ffba_pkg::KIND_FREE: st = heap_free(req.block_address);
			ffba_pkg::KIND_RESIZE: begin
				if (req.block_address == 0)
					st = heap_alloc(req.request_size, addr);
				else if (req.request_size == 0)
					st = heap_free(req.block_address);
				else begin
					idx = lookup_block(req.block_address);
					if (idx < 0)
						st = ffba_pkg::ST_BAD;
					else if (blk_size[idx] >= req.request_size)
						addr = req.block_address;
					else begin
						st = heap_alloc(req.request_size, addr);
						if (st == ffba_pkg::ST_OK)
							release_block(idx);
					end
				end
			end
			default: ;
		endcase
		res.result_address = addr;
		res.status = st;
		res.block_count = 7'(blk_count);
		res.heap_used = brk;
		return res;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		ffba_pkg::out_item_t exp_item;
		if (!arst_n) begin
			blk_count = 0;
			brk = '0;
			hdr_cfg = 7'd32;
			limit_cfg = 32'd65536;
			expected_q = {};
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ffba_pkg::CFG_HEADER)
					hdr_cfg = cfg_wdata[6:0];
				else
					limit_cfg = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat %p", out_data);
				end else begin
					exp_item = expected_q.pop_front();
					if (out_data !== exp_item) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", exp_item, out_data);
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(apply_request(in_data));
		end
	end
endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	ffba_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	ffba_pkg::out_item_t out_data;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_wdata;
	int fail_count;
	int pending;
	bit hold_out;
	int idle_cycles;
	logic [31:0] live_addr [$];

	first_fit_block_allocator dut (.*);

	ffba_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: count cycles with no beat on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("** first_fit_block_allocator: FAILED **");
			$finish;
		end
	end

	// Receiver: a random wait before each beat, plus one long hold-off on request.
	initial begin
		int wait_n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_out) begin
				repeat (1500) @(negedge clk);
				hold_out = 1'b0;
			end
			wait_n = $urandom_range(0, 4);
			repeat (wait_n) @(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
			out_ready = 1'b0;
		end
	end

	// Remember addresses handed back so frees and resizes hit live blocks.
	always @(posedge clk)
		if (out_valid && out_ready && out_data.result_address != 0) begin
			live_addr.push_back(out_data.result_address);
			if (live_addr.size() > 128)
				void'(live_addr.pop_front());
		end

	task automatic send(input logic [1:0] kind, input logic [31:0] size,
			input logic [31:0] addr, input bit gaps);
		if (gaps)
			repeat ($urandom_range(0, 4)) @(negedge clk);
		in_data = '{kind: kind, request_size: size, block_address: addr};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_index = idx;
		cfg_wdata = val;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [31:0] pick_addr();
		if (live_addr.size() == 0 || $urandom_range(0, 9) == 0)
			return ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
		return live_addr[$urandom_range(0, live_addr.size() - 1)];
	endfunction

	task automatic random_phase(input int count, input int max_size);
		logic [1:0] kind;
		logic [31:0] size;
		for (int n = 0; n < count; n++) begin
			kind = 2'($urandom_range(0, 2));
			if ($urandom_range(0, 49) == 0)
				kind = 2'd3;
			size = $urandom_range(0, max_size);
			if ($urandom_range(0, 29) == 0)
				size = $urandom;
			send(kind, size, pick_addr(), 1'b1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = ffba_pkg::CFG_HEADER;
		cfg_wdata = '0;
		hold_out = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, every kind and the special cases.
		send(ffba_pkg::KIND_ALLOC, 32'd0, 32'd0, 1'b0);
		send(ffba_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'd0, 1'b0);
		send(ffba_pkg::KIND_ALLOC, 32'd100, 32'd0, 1'b0);
		send(ffba_pkg::KIND_ALLOC, 32'd200, 32'd0, 1'b0);
		send(ffba_pkg::KIND_ALLOC, 32'd50, 32'd0, 1'b0);
		send(ffba_pkg::KIND_FREE, 32'd0, 32'd32, 1'b0);
		send(ffba_pkg::KIND_ALLOC, 32'd80, 32'd0, 1'b0);
		send(ffba_pkg::KIND_FREE, 32'd0, 32'd0, 1'b0);
		send(ffba_pkg::KIND_FREE, 32'd0, 32'hFFFF_FFFF, 1'b0);
		send(ffba_pkg::KIND_RESIZE, 32'd10, 32'd0, 1'b0);
		send(ffba_pkg::KIND_RESIZE, 32'd0, 32'd164, 1'b0);
		send(ffba_pkg::KIND_RESIZE, 32'd150, 32'd164, 1'b0);
		send(ffba_pkg::KIND_RESIZE, 32'd500, 32'd32, 1'b0);
		send(ffba_pkg::KIND_RESIZE, 32'hFFFF_FFFF, 32'd32, 1'b0);
		send(ffba_pkg::KIND_RESIZE, 32'd5, 32'd12345, 1'b0);
		send(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		drain();

		// Header change: old addresses become unknown; zero header acts as one.
		write_reg(ffba_pkg::CFG_HEADER, 32'd0);
		send(ffba_pkg::KIND_FREE, 32'd0, 32'd32, 1'b0);
		send(ffba_pkg::KIND_ALLOC, 32'd1, 32'd0, 1'b0);
		drain();
		write_reg(ffba_pkg::CFG_HEADER, 32'd64);
		write_reg(ffba_pkg::CFG_LIMIT, 32'hFFFF_FFFF);
		send(ffba_pkg::KIND_ALLOC, 32'hFFFF_FF00, 32'd0, 1'b0);
		send(ffba_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'd0, 1'b0);
		drain();

		// Table full: many small blocks under a large limit.
		write_reg(ffba_pkg::CFG_HEADER, 32'd1);
		write_reg(ffba_pkg::CFG_LIMIT, 32'd1_000_000);
		for (int i = 0; i < 70; i++)
			send(ffba_pkg::KIND_ALLOC, 32'd4, 32'd0, 1'b1);
		// Long receiver hold-off while items keep coming.
		hold_out = 1'b1;
		random_phase(200, 16);
		drain();

		// Sender pause until every result has arrived.
		write_reg(ffba_pkg::CFG_HEADER, 32'd127);
		write_reg(ffba_pkg::CFG_LIMIT, 32'd0);
		random_phase(30, 64);
		drain();
		write_reg(ffba_pkg::CFG_LIMIT, 32'd4096);
		random_phase(400, 300);
		drain();
		write_reg(ffba_pkg::CFG_HEADER, 32'd32);
		write_reg(ffba_pkg::CFG_LIMIT, 32'd65536);
		random_phase(600, 2000);
		drain();
		write_reg(ffba_pkg::CFG_HEADER, 32'd8);
		write_reg(ffba_pkg::CFG_LIMIT, 32'd2000);
		random_phase(420, 100);
		drain();

		if (fail_count == 0)
			$display("** first_fit_block_allocator: PASSED **");
		else
			$display("** first_fit_block_allocator: FAILED **");
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/ffba_pkg.sv
rtl/core/first_fit_block_allocator.sv
tb/ffba_checker.sv
tb/tb.sv
